// ----- design/campp_pkg.sv -----
// Shared widths, constants and payload types of the camera perspective projection block.
package campp_pkg;

    localparam int PT_W      = 24;
    localparam int TRIG_W    = 16;
    localparam int SCR_W     = 16;
    localparam int FRAC_BITS = 8;
    localparam int ROT_BITS  = 14;

    // Widths of the rotation datapath.
    localparam int DIFF_W = PT_W + 1;
    localparam int PROD_W = DIFF_W + TRIG_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int HALF_W = SUM_W / 2;
    localparam int PART_W = HALF_W + 1 + TRIG_W;
    localparam int ROT_W  = 60;
    localparam int NUM_W  = ROT_W;

    // Widths of the divider and the projection.
    localparam int QUO_W = SCR_W + 1;
    localparam int REM_W = NUM_W + QUO_W - 1;
    localparam int VAL_W = QUO_W + 2;

    localparam int PROJ_GAIN  = 240;
    localparam int CENTER_X   = 400;
    localparam int CENTER_Y   = 300;
    localparam int NEAR_UNITS = 20;
    localparam int SCR_MAX    = 32767;
    localparam int SCR_MIN    = -32768;

    localparam logic signed [ROT_W-1:0] NEAR_DEPTH =
        ROT_W'(NEAR_UNITS) <<< (FRAC_BITS + 2 * ROT_BITS);
    localparam logic signed [SCR_W-1:0] BEHIND_MARK = SCR_W'(-9999);

    localparam int APB_ADDR_W       = 5;
    localparam int APB_DATA_W       = 32;
    localparam int QUEUE_DEPTH_DEF  = 4;

    typedef enum logic [2:0] {
        REG_CAMERA_X     = 3'd0,
        REG_CAMERA_Y     = 3'd1,
        REG_CAMERA_Z     = 3'd2,
        REG_YAW_COSINE   = 3'd3,
        REG_YAW_SINE     = 3'd4,
        REG_PITCH_COSINE = 3'd5,
        REG_PITCH_SINE   = 3'd6
    } campp_reg_t;

    typedef struct packed {
        logic signed [PT_W-1:0] point_x;
        logic signed [PT_W-1:0] point_y;
        logic signed [PT_W-1:0] point_z;
    } campp_point_t;

    typedef struct packed {
        logic signed [SCR_W-1:0] screen_x;
        logic signed [SCR_W-1:0] screen_y;
        logic                    behind_camera;
    } campp_pixel_t;

    typedef struct packed {
        logic [PT_W-1:0]   camera_x;
        logic [PT_W-1:0]   camera_y;
        logic [PT_W-1:0]   camera_z;
        logic [TRIG_W-1:0] yaw_cosine;
        logic [TRIG_W-1:0] yaw_sine;
        logic [TRIG_W-1:0] pitch_cosine;
        logic [TRIG_W-1:0] pitch_sine;
    } campp_cam_t;

    // A classified point on its way from the front part to the divider.
    typedef struct packed {
        logic             behind;
        logic             neg_x;
        logic             neg_y;
        logic [NUM_W-1:0] num_x;
        logic [NUM_W-1:0] num_y;
        logic [NUM_W-1:0] den;
    } campp_job_t;

    localparam campp_cam_t CAM_RESET = '{
        camera_x:     '0,
        camera_y:     '0,
        camera_z:     '0,
        yaw_cosine:   TRIG_W'(16384),
        yaw_sine:     '0,
        pitch_cosine: TRIG_W'(16384),
        pitch_sine:   '0
    };

endpackage

// ----- design/campp_front.sv -----
// Front part: camera offset, yaw and pitch rotation, and near-plane classification.
module campp_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  campp_pkg::campp_cam_t cam,
    input  logic                  point_valid,
    output logic                  point_ready,
    input  campp_pkg::campp_point_t point,
    output logic                  job_valid,
    input  logic                  job_ready,
    output campp_pkg::campp_job_t job
);
    import campp_pkg::*;

    localparam int STAGES = 7;

    logic adv;
    logic [STAGES-1:0] vld_reg;

    logic signed [TRIG_W-1:0] cy, sy, cp, sp;

    logic signed [DIFF_W-1:0] dx_reg, dy_reg, dz_reg, dx_next, dy_next, dz_next;
    logic signed [PROD_W-1:0] xc_reg, zs_reg, xs_reg, zc_reg, yc_reg, ys_reg;
    logic signed [PROD_W-1:0] xc_next, zs_next, xs_next, zc_next, yc_next, ys_next;
    logic signed [SUM_W-1:0]  rx1_reg, rz1_reg, rx1_next, rz1_next;
    logic signed [PROD_W-1:0] yc_s3_reg, ys_s3_reg;
    logic signed [SUM_W-HALF_W-1:0] rz1_hi;
    logic signed [HALF_W:0]   rz1_lo;
    logic signed [PART_W-1:0] hs_reg, ls_reg, hc_reg, lc_reg;
    logic signed [PART_W-1:0] hs_next, ls_next, hc_next, lc_next;
    logic signed [SUM_W-1:0]  rx1_s4_reg, rx1_s5_reg, rx1_s6_reg;
    logic signed [PROD_W-1:0] yc_s4_reg, ys_s4_reg, yc_s5_reg, ys_s5_reg;
    logic signed [ROT_W-1:0]  rzsp_reg, rzcp_reg, rzsp_next, rzcp_next;
    logic signed [ROT_W-1:0]  ry2_reg, rz2_reg, ry2_next, rz2_next;
    logic [SUM_W-1:0]         rx1_mag;
    campp_job_t               job_reg, job_next;

    assign cy = cam.yaw_cosine;
    assign sy = cam.yaw_sine;
    assign cp = cam.pitch_cosine;
    assign sp = cam.pitch_sine;

    // The whole front advances together unless a finished job cannot enter the queue.
    assign adv         = !(vld_reg[STAGES-1] && !job_ready);
    assign point_ready = adv;
    assign job_valid   = vld_reg[STAGES-1];
    assign job         = job_reg;

    assign rz1_hi = rz1_reg[SUM_W-1:HALF_W];
    assign rz1_lo = {1'b0, rz1_reg[HALF_W-1:0]};

    always_comb
    begin
        dx_next = DIFF_W'(point.point_x) - DIFF_W'($signed(cam.camera_x));
        dy_next = DIFF_W'(point.point_y) - DIFF_W'($signed(cam.camera_y));
        dz_next = DIFF_W'(point.point_z) - DIFF_W'($signed(cam.camera_z));

        xc_next = dx_reg * cy;
        zs_next = dz_reg * sy;
        xs_next = dx_reg * sy;
        zc_next = dz_reg * cy;
        yc_next = dy_reg * cp;
        ys_next = dy_reg * sp;

        rx1_next = xc_reg - zs_reg;
        rz1_next = xs_reg + zc_reg;

        // The yawed depth is too wide for one multiplier, so it is taken in two halves.
        hs_next = rz1_hi * sp;
        ls_next = rz1_lo * sp;
        hc_next = rz1_hi * cp;
        lc_next = rz1_lo * cp;

        rzsp_next = (ROT_W'(hs_reg) <<< HALF_W) + ROT_W'(ls_reg);
        rzcp_next = (ROT_W'(hc_reg) <<< HALF_W) + ROT_W'(lc_reg);

        ry2_next = (ROT_W'(yc_s5_reg) <<< ROT_BITS) - rzsp_reg;
        rz2_next = (ROT_W'(ys_s5_reg) <<< ROT_BITS) + rzcp_reg;

        rx1_mag          = rx1_s6_reg[SUM_W-1] ? SUM_W'(-rx1_s6_reg) : SUM_W'(rx1_s6_reg);
        job_next.behind  = (rz2_reg < NEAR_DEPTH);
        job_next.neg_x   = rx1_s6_reg[SUM_W-1];
        job_next.num_x   = NUM_W'(rx1_mag) << ROT_BITS;
        // The row is projected from the negated height.
        job_next.neg_y   = !ry2_reg[ROT_W-1] && (ry2_reg != '0);
        job_next.num_y   = ry2_reg[ROT_W-1] ? NUM_W'(-ry2_reg) : NUM_W'(ry2_reg);
        job_next.den     = NUM_W'(rz2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], point_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            dz_reg     <= dz_next;
            xc_reg     <= xc_next;
            zs_reg     <= zs_next;
            xs_reg     <= xs_next;
            zc_reg     <= zc_next;
            yc_reg     <= yc_next;
            ys_reg     <= ys_next;
            rx1_reg    <= rx1_next;
            rz1_reg    <= rz1_next;
            yc_s3_reg  <= yc_reg;
            ys_s3_reg  <= ys_reg;
            hs_reg     <= hs_next;
            ls_reg     <= ls_next;
            hc_reg     <= hc_next;
            lc_reg     <= lc_next;
            rx1_s4_reg <= rx1_reg;
            yc_s4_reg  <= yc_s3_reg;
            ys_s4_reg  <= ys_s3_reg;
            rzsp_reg   <= rzsp_next;
            rzcp_reg   <= rzcp_next;
            rx1_s5_reg <= rx1_s4_reg;
            yc_s5_reg  <= yc_s4_reg;
            ys_s5_reg  <= ys_s4_reg;
            ry2_reg    <= ry2_next;
            rz2_reg    <= rz2_next;
            rx1_s6_reg <= rx1_s5_reg;
            job_reg    <= job_next;
        end
    end

endmodule

// ----- design/campp_queue.sv -----
// Short job queue that lets the front part and the divider stall independently.
module campp_queue #(
    parameter int DEPTH = campp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  campp_pkg::campp_job_t push_data,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output campp_pkg::campp_job_t pop_data
);
    import campp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    campp_job_t        mem_reg [DEPTH];
    logic [PTR_W-1:0]  head_reg, head_next, tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[head_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            tail_next = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (pop)
        begin
            head_next = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[tail_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not rise on a lone push");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count did not fall on a lone pop");

    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !push_ready |-> pop_valid)
        else $error("queue reports full and empty at once");

    a_first_through: assert property (@(posedge clk) disable iff (!rst_n)
        (push && (count_reg == '0)) |=> pop_valid && (pop_data == $past(push_data)))
        else $error("job pushed into an empty queue is not at its head");
`endif

endmodule

// ----- design/campp_back.sv -----
// Back part: pipelined restoring divider and screen projection with saturation.
module campp_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    job_valid,
    output logic                    job_ready,
    input  campp_pkg::campp_job_t   job,
    output logic                    pixel_valid,
    input  logic                    pixel_ready,
    output campp_pkg::campp_pixel_t pixel
);
    import campp_pkg::*;

    logic adv;

    // Stage 0 holds the scaled numerators; stage k has settled quotient bit QUO_W-k.
    logic [QUO_W:0]     vld_reg, vld_next;
    logic [QUO_W:0]     behind_reg, behind_next;
    logic [QUO_W:0]     negx_reg, negx_next;
    logic [QUO_W:0]     negy_reg, negy_next;
    logic [NUM_W-1:0]   den_reg  [0:QUO_W];
    logic [NUM_W-1:0]   den_next [0:QUO_W];
    logic [REM_W-1:0]   remx_reg [0:QUO_W];
    logic [REM_W-1:0]   remx_next[0:QUO_W];
    logic [REM_W-1:0]   remy_reg [0:QUO_W];
    logic [REM_W-1:0]   remy_next[0:QUO_W];
    logic [QUO_W-1:0]   quox_reg [0:QUO_W];
    logic [QUO_W-1:0]   quox_next[0:QUO_W];
    logic [QUO_W-1:0]   quoy_reg [0:QUO_W];
    logic [QUO_W-1:0]   quoy_next[0:QUO_W];
    logic [REM_W-1:0]   dsh      [1:QUO_W];

    logic signed [VAL_W-1:0] magx, magy, valx, valy;
    logic                    pixel_valid_reg;
    campp_pixel_t            pixel_reg, pixel_next;

    function automatic logic signed [SCR_W-1:0] clamp_screen(input logic signed [VAL_W-1:0] v);
        logic signed [SCR_W-1:0] r;
        if (v > VAL_W'(SCR_MAX))
        begin
            r = SCR_W'(SCR_MAX);
        end
        else if (v < VAL_W'(SCR_MIN))
        begin
            r = SCR_W'(SCR_MIN);
        end
        else
        begin
            r = v[SCR_W-1:0];
        end
        return r;
    endfunction

    // The pipeline moves as a whole whenever the output register is free or being taken.
    assign adv         = !pixel_valid_reg || pixel_ready;
    assign job_ready   = adv;
    assign pixel_valid = pixel_valid_reg;
    assign pixel       = pixel_reg;

    always_comb
    begin
        vld_next    = {vld_reg[QUO_W-1:0], job_valid};
        behind_next = {behind_reg[QUO_W-1:0], job.behind};
        negx_next   = {negx_reg[QUO_W-1:0], job.neg_x};
        negy_next   = {negy_reg[QUO_W-1:0], job.neg_y};

        den_next[0]  = job.den;
        remx_next[0] = REM_W'(job.num_x) * REM_W'(PROJ_GAIN);
        remy_next[0] = REM_W'(job.num_y) * REM_W'(PROJ_GAIN);
        quox_next[0] = '0;
        quoy_next[0] = '0;

        // A set top quotient bit means the magnitude is past any on-screen value.
        for (int k = 1; k <= QUO_W; k++)
        begin
            dsh[k]      = REM_W'(den_reg[k-1]) << (QUO_W - k);
            den_next[k] = den_reg[k-1];
            if (remx_reg[k-1] >= dsh[k])
            begin
                remx_next[k] = remx_reg[k-1] - dsh[k];
                quox_next[k] = quox_reg[k-1] | (QUO_W'(1) << (QUO_W - k));
            end
            else
            begin
                remx_next[k] = remx_reg[k-1];
                quox_next[k] = quox_reg[k-1];
            end
            if (remy_reg[k-1] >= dsh[k])
            begin
                remy_next[k] = remy_reg[k-1] - dsh[k];
                quoy_next[k] = quoy_reg[k-1] | (QUO_W'(1) << (QUO_W - k));
            end
            else
            begin
                remy_next[k] = remy_reg[k-1];
                quoy_next[k] = quoy_reg[k-1];
            end
        end

        magx = VAL_W'(quox_reg[QUO_W]);
        magy = VAL_W'(quoy_reg[QUO_W]);
        valx = (negx_reg[QUO_W] ? -magx : magx) + VAL_W'(CENTER_X);
        valy = (negy_reg[QUO_W] ? -magy : magy) + VAL_W'(CENTER_Y);

        if (behind_reg[QUO_W])
        begin
            pixel_next.screen_x = BEHIND_MARK;
            pixel_next.screen_y = BEHIND_MARK;
        end
        else
        begin
            pixel_next.screen_x = clamp_screen(valx);
            pixel_next.screen_y = clamp_screen(valy);
        end
        pixel_next.behind_camera = behind_reg[QUO_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg         <= '0;
            pixel_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg         <= vld_next;
            pixel_valid_reg <= vld_reg[QUO_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            behind_reg <= behind_next;
            negx_reg   <= negx_next;
            negy_reg   <= negy_next;
            for (int k = 0; k <= QUO_W; k++)
            begin
                den_reg[k]  <= den_next[k];
                remx_reg[k] <= remx_next[k];
                remy_reg[k] <= remy_next[k];
                quox_reg[k] <= quox_next[k];
                quoy_reg[k] <= quoy_next[k];
            end
            pixel_reg <= pixel_next;
        end
    end

endmodule

// ----- design/camera_perspective_projection.sv -----
// Camera perspective projection: one world point in Q15.8 per transfer gives one screen
// position. The point is offset by the camera position, rotated by yaw and then pitch
// using the Q1.14 sine and cosine registers, and projected to column trunc(x*240/depth)+400
// and row trunc(-y*240/depth)+300, saturated to 16 bits; a depth below 20 sets
// behind_camera and both coordinates to -9999. The block accepts one point every clock and
// delivers one result every clock while the output is taken. With no stalls, a point
// passes through seven rotation stages, the job queue register, a scaling stage, seventeen
// restoring divider stages (one quotient bit each) and the output register. Registers are
// written over the APB port at byte address 4*index and should only be changed while no
// point is in flight.
module camera_perspective_projection #(
    parameter int QUEUE_DEPTH = campp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [campp_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [campp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [campp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                 pready,
    input  logic                                 point_valid,
    output logic                                 point_ready,
    input  campp_pkg::campp_point_t              point,
    output logic                                 pixel_valid,
    input  logic                                 pixel_ready,
    output campp_pkg::campp_pixel_t              pixel
);
    import campp_pkg::*;

    campp_cam_t cam_reg, cam_next;
    campp_reg_t reg_idx;
    logic       cfg_write;

    logic       fr_valid, fr_ready, bk_valid, bk_ready;
    campp_job_t fr_job, bk_job;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = campp_reg_t'(paddr[APB_ADDR_W-1:2]);

    always_comb
    begin
        cam_next = cam_reg;
        if (cfg_write)
        begin
            case (reg_idx)
                REG_CAMERA_X:     cam_next.camera_x     = pwdata[PT_W-1:0];
                REG_CAMERA_Y:     cam_next.camera_y     = pwdata[PT_W-1:0];
                REG_CAMERA_Z:     cam_next.camera_z     = pwdata[PT_W-1:0];
                REG_YAW_COSINE:   cam_next.yaw_cosine   = pwdata[TRIG_W-1:0];
                REG_YAW_SINE:     cam_next.yaw_sine     = pwdata[TRIG_W-1:0];
                REG_PITCH_COSINE: cam_next.pitch_cosine = pwdata[TRIG_W-1:0];
                REG_PITCH_SINE:   cam_next.pitch_sine   = pwdata[TRIG_W-1:0];
                default:          cam_next              = cam_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_CAMERA_X:     prdata = APB_DATA_W'(cam_reg.camera_x);
            REG_CAMERA_Y:     prdata = APB_DATA_W'(cam_reg.camera_y);
            REG_CAMERA_Z:     prdata = APB_DATA_W'(cam_reg.camera_z);
            REG_YAW_COSINE:   prdata = APB_DATA_W'(cam_reg.yaw_cosine);
            REG_YAW_SINE:     prdata = APB_DATA_W'(cam_reg.yaw_sine);
            REG_PITCH_COSINE: prdata = APB_DATA_W'(cam_reg.pitch_cosine);
            REG_PITCH_SINE:   prdata = APB_DATA_W'(cam_reg.pitch_sine);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_reg <= CAM_RESET;
        end
        else
        begin
            cam_reg <= cam_next;
        end
    end

    campp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cam         (cam_reg),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point       (point),
        .job_valid   (fr_valid),
        .job_ready   (fr_ready),
        .job         (fr_job)
    );

    campp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_data  (fr_job),
        .pop_valid  (bk_valid),
        .pop_ready  (bk_ready),
        .pop_data   (bk_job)
    );

    campp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (bk_valid),
        .job_ready   (bk_ready),
        .job         (bk_job),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel)
    );

endmodule
